@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file msp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MSP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/msp_pkg.sv @@
`default_nettype none

package msp_pkg;

   // Result word kinds
   localparam logic [2:0] KIND_REPLY   = 3'd0;
   localparam logic [2:0] KIND_TOPIC   = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD = 3'd2;
   localparam logic [2:0] KIND_DONE    = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;
   localparam logic [2:0] KIND_HANGUP  = 3'd5;

   // Commands passed from the parser to the result sequencer
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_TOPIC    = 3'd1;
   localparam logic [2:0] OP_PAYLOAD  = 3'd2;
   localparam logic [2:0] OP_PUBACK   = 3'd3;
   localparam logic [2:0] OP_CONNACK  = 3'd4;
   localparam logic [2:0] OP_PINGRESP = 3'd5;
   localparam logic [2:0] OP_ERROR    = 3'd6;
   localparam logic [2:0] OP_HANGUP   = 3'd7;

   // Reply header bytes
   localparam logic [7:0] HDR_CONNACK  = 8'h20;
   localparam logic [7:0] HDR_PINGRESP = 8'hD0;
   localparam logic [7:0] HDR_PUBACK   = 8'h40;
   localparam logic [7:0] HDR_PUBREC   = 8'h50;
   localparam logic [7:0] REPLY_LEN    = 8'h02;
   localparam logic [7:0] CONNACK_SP   = 8'h01;
   localparam logic [7:0] BYTE_ZERO    = 8'h00;

   localparam logic [1:0] QOS_ONE = 2'd1;

   typedef struct packed {
      logic [2:0]  op;
      logic        done;
      logic [1:0]  qos;
      logic [15:0] data;
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/msp_if.sv @@
`default_nettype none

// Received byte channel
interface msp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       conn_start;

   modport source (output valid, output in_byte, output conn_start, input ready);
   modport sink (input valid, input in_byte, input conn_start, output ready);
endinterface

// Result word channel
interface msp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] out_kind;
   logic [7:0] out_byte;
   logic [1:0] out_qos;
   logic       out_last;

   modport source (output valid, output out_kind, output out_byte, output out_qos,
                   output out_last, input ready);
   modport sink (input valid, input out_kind, input out_byte, input out_qos,
                 input out_last, output ready);
endinterface

`default_nettype wire

@@ hdl/msp_front.sv @@
`default_nettype none

module msp_front #(
   parameter int MAX_LENGTH_BYTES = 3
) (
   input  wire logic          clock,
   input  wire logic          reset,
   msp_req_if.sink            req,
   input  wire logic          queue_full,
   output logic               cmd_push,
   output msp_pkg::cmd_type   cmd
);
   import msp_pkg::*;

   localparam int REM_W = 7 * MAX_LENGTH_BYTES;
   localparam int IDX_W = $clog2(MAX_LENGTH_BYTES + 1);
   localparam int CMP_W = ((REM_W > 17) ? REM_W : 17) + 1;

   // Parser phases
   localparam logic [3:0] PH_TYPE    = 4'd0;
   localparam logic [3:0] PH_LEN     = 4'd1;
   localparam logic [3:0] PH_SKIP    = 4'd2;
   localparam logic [3:0] PH_TLEN_HI = 4'd3;
   localparam logic [3:0] PH_TLEN_LO = 4'd4;
   localparam logic [3:0] PH_TOPIC   = 4'd5;
   localparam logic [3:0] PH_PID_HI  = 4'd6;
   localparam logic [3:0] PH_PID_LO  = 4'd7;
   localparam logic [3:0] PH_PAYLOAD = 4'd8;

   // Packet types
   localparam logic [3:0] T_CONNECT    = 4'd1;
   localparam logic [3:0] T_PUBLISH    = 4'd3;
   localparam logic [3:0] T_PINGREQ    = 4'd12;
   localparam logic [3:0] T_DISCONNECT = 4'd14;

   localparam logic [1:0] QOS_BAD = 2'd3;

   logic [3:0]       phase_ff, phase_in;
   logic             connected_ff, connected_in;
   logic             halted_ff, halted_in;
   logic [3:0]       kind_ff, kind_in;
   logic [1:0]       qos_ff, qos_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       tlen_hi_ff, tlen_hi_in;
   logic [15:0]      tleft_ff, tleft_in;
   logic [7:0]       pid_hi_ff, pid_hi_in;

   logic [3:0]       cur_phase;
   logic             cur_connected;
   logic             cur_halted;
   logic [7:0]       b;
   logic             accept;
   logic             fail;
   logic             finish;
   logic [2:0]       op;
   logic [15:0]      tlen;
   logic [CMP_W-1:0] tlen_ext;
   logic [CMP_W-1:0] rem_ext;

   assign b         = req.in_byte;
   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign tlen      = {tlen_hi_ff, b};
   assign tlen_ext  = CMP_W'(tlen);
   assign rem_ext   = CMP_W'(rem_in);

   // Apply a connection restart ahead of the byte
   always_comb begin
      cur_phase     = req.conn_start ? PH_TYPE : phase_ff;
      cur_connected = req.conn_start ? 1'b0 : connected_ff;
      cur_halted    = req.conn_start ? 1'b0 : halted_ff;
   end

   // Parse one byte
   always_comb begin
      phase_in     = cur_phase;
      connected_in = cur_connected;
      halted_in    = cur_halted;
      kind_in      = kind_ff;
      qos_in       = qos_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      tlen_hi_in   = tlen_hi_ff;
      tleft_in     = tleft_ff;
      pid_hi_in    = pid_hi_ff;
      fail         = 1'b0;
      finish       = 1'b0;
      op           = OP_NONE;
      cmd.data     = {8'h00, b};

      if (!cur_halted) begin
         unique case (cur_phase)
            PH_TYPE: begin
               kind_in = b[7:4];
               qos_in  = (b[7:4] == T_PUBLISH) ? b[2:1] : 2'd0;
               rem_in  = '0;
               idx_in  = '0;
               if ((!cur_connected && b[7:4] != T_CONNECT) || qos_in == QOS_BAD) begin
                  fail = 1'b1;
               end else begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (idx_ff >= IDX_W'(MAX_LENGTH_BYTES)) begin
                  fail = 1'b1;
               end else begin
                  // Merge seven length bits at the current byte position
                  for (int k = 0; k < MAX_LENGTH_BYTES; k++) begin
                     if (idx_ff == IDX_W'(k)) begin
                        rem_in[7*k +: 7] = rem_ff[7*k +: 7] | b[6:0];
                     end
                  end
                  idx_in = IDX_W'(idx_ff + 1'b1);
                  if (!b[7]) begin
                     if (kind_ff == T_PUBLISH) begin
                        if (rem_in < REM_W'(2)) begin
                           fail = 1'b1;
                        end else begin
                           phase_in = PH_TLEN_HI;
                        end
                     end else if (rem_in == '0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               end
            end
            default: begin
               rem_in = rem_ff - 1'b1;
               unique case (cur_phase)
                  PH_TLEN_HI: begin
                     tlen_hi_in = b;
                     phase_in   = PH_TLEN_LO;
                  end
                  PH_TLEN_LO: begin
                     tleft_in = tlen;
                     if (tlen_ext > rem_ext) begin
                        fail = 1'b1;
                     end else if (qos_ff != 2'd0 && tlen_ext + CMP_W'(2) > rem_ext) begin
                        fail = 1'b1;
                     end else if (tlen != 16'd0) begin
                        phase_in = PH_TOPIC;
                     end else begin
                        phase_in = (qos_ff != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
                     end
                  end
                  PH_TOPIC: begin
                     op       = OP_TOPIC;
                     tleft_in = tleft_ff - 1'b1;
                     if (tleft_in == 16'd0) begin
                        phase_in = (qos_ff != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
                     end
                  end
                  PH_PID_HI: begin
                     pid_hi_in = b;
                     phase_in  = PH_PID_LO;
                  end
                  PH_PID_LO: begin
                     op       = OP_PUBACK;
                     cmd.data = {pid_hi_ff, b};
                     phase_in = PH_PAYLOAD;
                  end
                  PH_PAYLOAD: begin
                     op = OP_PAYLOAD;
                  end
                  default: begin
                  end
               endcase
               if (!fail && rem_in == '0) begin
                  finish = 1'b1;
               end
            end
         endcase
      end

      // Turn errors and packet ends into commands
      cmd.op   = op;
      cmd.done = 1'b0;
      cmd.qos  = qos_in;
      if (fail) begin
         cmd.op    = OP_ERROR;
         halted_in = 1'b1;
         phase_in  = PH_TYPE;
      end else if (finish) begin
         phase_in = PH_TYPE;
         cmd.done = 1'b1;
         if (op == OP_NONE) begin
            priority if (kind_in == T_CONNECT) begin
               cmd.op       = OP_CONNACK;
               connected_in = 1'b1;
            end else if (kind_in == T_PINGREQ) begin
               cmd.op = OP_PINGRESP;
            end else if (kind_in == T_DISCONNECT) begin
               cmd.op    = OP_HANGUP;
               cmd.done  = 1'b0;
               halted_in = 1'b1;
            end else begin
               // other types only close the packet
            end
         end
      end
      cmd_push = accept && (fail || finish || op != OP_NONE);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         connected_ff <= 1'b0;
         halted_ff    <= 1'b0;
         kind_ff      <= '0;
         qos_ff       <= '0;
         rem_ff       <= '0;
         idx_ff       <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         connected_ff <= connected_in;
         halted_ff    <= halted_in;
         kind_ff      <= kind_in;
         qos_ff       <= qos_in;
         rem_ff       <= rem_in;
         idx_ff       <= idx_in;
      end
   end

   // Topic and packet id holding registers
   always_ff @(posedge clock) begin
      if (accept) begin
         tlen_hi_ff <= tlen_hi_in;
         tleft_ff   <= tleft_in;
         pid_hi_ff  <= pid_hi_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/msp_fifo.sv @@
`default_nettype none

module msp_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire msp_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output msp_pkg::cmd_type      head,
   output logic                  empty,
   output logic                  full
);
   import msp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ hdl/msp_back.sv @@
`default_nettype none

module msp_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire msp_pkg::cmd_type head,
   input  wire logic             empty,
   output logic                  pop,
   msp_rsp_if.source             rsp
);
   import msp_pkg::*;

   logic       valid_ff;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] qos_ff;
   logic       last_ff, last_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] n_body;
   logic [2:0] total;
   logic       load;

   assign rsp.valid    = valid_ff;
   assign rsp.out_kind = kind_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.out_qos  = qos_ff;
   assign rsp.out_last = last_ff;

   assign load = !empty && (!valid_ff || rsp.ready);
   assign pop  = load && last_in;

   // Pick the word at the current position of the command
   always_comb begin
      n_body  = 3'd1;
      kind_in = KIND_DONE;
      byte_in = BYTE_ZERO;
      unique case (head.op)
         OP_NONE: begin
            n_body = 3'd0;
         end
         OP_TOPIC: begin
            kind_in = KIND_TOPIC;
            byte_in = head.data[7:0];
         end
         OP_PAYLOAD: begin
            kind_in = KIND_PAYLOAD;
            byte_in = head.data[7:0];
         end
         OP_ERROR: begin
            kind_in = KIND_ERROR;
         end
         OP_HANGUP: begin
            kind_in = KIND_HANGUP;
         end
         OP_CONNACK: begin
            n_body  = 3'd4;
            kind_in = KIND_REPLY;
            unique case (idx_ff[1:0])
               2'd0: byte_in = HDR_CONNACK;
               2'd1: byte_in = REPLY_LEN;
               2'd2: byte_in = CONNACK_SP;
               2'd3: byte_in = BYTE_ZERO;
            endcase
         end
         OP_PINGRESP: begin
            n_body  = 3'd2;
            kind_in = KIND_REPLY;
            byte_in = (idx_ff[0] == 1'b0) ? HDR_PINGRESP : BYTE_ZERO;
         end
         OP_PUBACK: begin
            n_body  = 3'd4;
            kind_in = KIND_REPLY;
            unique case (idx_ff[1:0])
               2'd0: byte_in = (head.qos == QOS_ONE) ? HDR_PUBACK : HDR_PUBREC;
               2'd1: byte_in = REPLY_LEN;
               2'd2: byte_in = head.data[15:8];
               2'd3: byte_in = head.data[7:0];
            endcase
         end
      endcase
      // Past the body only the packet-done word remains
      if (idx_ff >= n_body) begin
         kind_in = KIND_DONE;
         byte_in = BYTE_ZERO;
      end
      total   = n_body + {2'b00, head.done};
      last_in = (3'(idx_ff + 1'b1) == total);
      idx_in  = last_in ? 3'd0 : 3'(idx_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Hold the word until taken
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         qos_ff  <= head.qos;
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/mqtt_server_packet_parser.sv @@
// MQTT server-side fixed header parser.
// req_chan carries one received byte (in_byte) per word; conn_start set on a
// word restarts the connection state before that byte is parsed. rsp_chan
// carries result words: reply, topic and payload bytes plus packet-done,
// error and hangup markers, with out_last on the final word of a byte.
// The parser takes one byte per cycle unless the queue is full and updates
// its state at once; each byte that yields results queues one command in a
// four-entry queue. The result sequencer expands a command into one to five
// words, one per cycle while rsp_chan is ready, behind an output register.
// Sustained rate is one byte per cycle while each byte gives at most one
// word and rsp_chan is ready; a byte with more words holds the output for
// all of them, and the queue fills and drops req ready when the output falls
// behind. A stalled rsp_chan holds its word stable; the parser keeps taking
// bytes until the queue is full. Reset clears the parser to await CONNECT,
// empties the queue and drops rsp valid. After an error or hangup all bytes
// are consumed without results until conn_start.
`default_nettype none

module mqtt_server_packet_parser #(
   parameter int MAX_LENGTH_BYTES = 3
) (
   input  wire logic clock,
   input  wire logic reset,
   msp_req_if.sink   req_chan,
   msp_rsp_if.source rsp_chan
);
   import msp_pkg::*;

   localparam int QUEUE_DEPTH = 4;

   cmd_type push_cmd;
   cmd_type head;
   logic    push;
   logic    pop;
   logic    empty;
   logic    full;

   msp_front #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .queue_full(full),
      .cmd_push  (push),
      .cmd       (push_cmd)
   );

   msp_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head    (head),
      .empty   (empty),
      .full    (full)
   );

   msp_back u_back (
      .clock(clock),
      .reset(reset),
      .head (head),
      .empty(empty),
      .pop  (pop),
      .rsp  (rsp_chan)
   );

endmodule

`default_nettype wire

@@ hdl/msp_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module msp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] out_kind,
   input wire logic [7:0] out_byte,
   input wire logic [1:0] out_qos,
   input wire logic       out_last
);
   import msp_pkg::*;

   logic stalled;
   logic status_word;

   assign stalled     = rsp_valid && !rsp_ready;
   assign status_word = rsp_valid &&
                        (out_kind == KIND_DONE || out_kind == KIND_ERROR ||
                         out_kind == KIND_HANGUP);

   // A stalled word stays offered
   `MSP_ASSERT_NEXT(a_stall_valid, stalled, rsp_valid, "rsp valid dropped while stalled")

   // A stalled word keeps its contents
   `MSP_ASSERT_NEXT(a_stall_hold, stalled, $stable(out_kind) && $stable(out_byte) && $stable(out_qos) && $stable(out_last), "rsp word changed while stalled")

   // Done, error and hangup always close the results of a byte
   `MSP_ASSERT_IMPLIES(a_status_last, status_word, out_last, "status word not last")

   // Status words carry no byte
   `MSP_ASSERT_IMPLIES(a_status_zero, status_word, out_byte == 8'h00, "status word with data")

endmodule

bind mqtt_server_packet_parser msp_checker u_msp_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .out_kind (rsp_chan.out_kind),
   .out_byte (rsp_chan.out_byte),
   .out_qos  (rsp_chan.out_qos),
   .out_last (rsp_chan.out_last)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import msp_pkg::*;

   // MQTT control packet types seen by the parser
   localparam logic [3:0] PKT_CONNECT    = 4'd1;
   localparam logic [3:0] PKT_PUBLISH    = 4'd3;
   localparam logic [3:0] PKT_PINGREQ    = 4'd12;
   localparam logic [3:0] PKT_DISCONNECT = 4'd14;

   localparam int MAX_LEN_BYTES = 3;
   localparam int RANDOM_ITEMS  = 290;
   localparam int DRAIN_CYCLES  = 20;
   localparam int LONG_HOLD     = 120;

   typedef enum logic [3:0] {
      AWAIT_TYPE,
      AWAIT_LENGTH,
      SKIP_BODY,
      TLEN_HIGH,
      TLEN_LOW,
      TOPIC_BYTES,
      IDENT_HIGH,
      IDENT_LOW,
      PAYLOAD_BYTES
   } parse_phase_type;

   typedef struct {
      logic [7:0] data;
      logic       conn_start;
   } rx_word_type;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] data;
      logic [1:0] qos;
      logic       last;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msp_req_if req_chan ();
   msp_rsp_if rsp_chan ();

   mqtt_server_packet_parser dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   // Byte stream still to send, and result words still to arrive
   rx_word_type     rx_stream[$];
   result_word_type expected_words[$];
   result_word_type step_words[$];

   int gen_counted = 0;
   int stream_total = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   logic link_up = 1'b0;
   logic [1:0] idle_phase = 2'd0;
   logic sender_hold = 1'b0;

   // Parser state mirror
   parse_phase_type ps_phase;
   logic            ps_connected;
   logic            ps_halted;
   logic [3:0]      ps_kind;
   logic [1:0]      ps_qos;
   logic [20:0]     ps_remaining;
   logic [1:0]      ps_len_index;
   logic [15:0]     ps_topic_len;
   logic [15:0]     ps_topic_left;
   logic [15:0]     ps_ident;

   rx_word_type     next_word;
   result_word_type want_word;
   int              hold_left = 0;
   logic            long_hold_done = 1'b0;

   function automatic void add_word(logic [2:0] kind, logic [7:0] data);
      result_word_type w;
      w.kind = kind;
      w.data = data;
      w.qos = ps_qos;
      w.last = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void raise_error();
      add_word(KIND_ERROR, BYTE_ZERO);
      ps_halted = 1'b1;
      ps_phase = AWAIT_TYPE;
   endfunction

   // Emit the replies due at the last byte of a packet
   function automatic void close_packet();
      ps_phase = AWAIT_TYPE;
      if (ps_kind == PKT_DISCONNECT) begin
         add_word(KIND_HANGUP, BYTE_ZERO);
         ps_halted = 1'b1;
      end else begin
         if (ps_kind == PKT_CONNECT) begin
            add_word(KIND_REPLY, HDR_CONNACK);
            add_word(KIND_REPLY, REPLY_LEN);
            add_word(KIND_REPLY, CONNACK_SP);
            add_word(KIND_REPLY, BYTE_ZERO);
            ps_connected = 1'b1;
         end else if (ps_kind == PKT_PINGREQ) begin
            add_word(KIND_REPLY, HDR_PINGRESP);
            add_word(KIND_REPLY, BYTE_ZERO);
         end
         add_word(KIND_DONE, BYTE_ZERO);
      end
   endfunction

   // Advance the parser mirror by one received byte, queue the words it yields
   task automatic parse_byte(input logic [7:0] b, input logic restart);
      logic bad_topic;
      step_words.delete();
      if (restart) begin
         ps_phase = AWAIT_TYPE;
         ps_connected = 1'b0;
         ps_halted = 1'b0;
         ps_kind = 4'd0;
         ps_qos = 2'd0;
         ps_remaining = 21'd0;
         ps_len_index = 2'd0;
         ps_topic_len = 16'd0;
         ps_topic_left = 16'd0;
         ps_ident = 16'd0;
      end
      if (!ps_halted) begin
         case (ps_phase)
            AWAIT_TYPE: begin
               ps_kind = b[7:4];
               ps_qos = (ps_kind == PKT_PUBLISH) ? b[2:1] : 2'd0;
               ps_remaining = 21'd0;
               ps_len_index = 2'd0;
               if (!ps_connected && ps_kind != PKT_CONNECT) begin
                  raise_error();
               end else if (ps_qos == 2'd3) begin
                  raise_error();
               end else begin
                  ps_phase = AWAIT_LENGTH;
               end
            end
            AWAIT_LENGTH: begin
               if (ps_len_index >= MAX_LEN_BYTES) begin
                  raise_error();
               end else begin
                  ps_remaining = ps_remaining | (21'(b[6:0]) << (7 * ps_len_index));
                  ps_len_index = ps_len_index + 2'd1;
                  if (!b[7]) begin
                     if (ps_kind == PKT_PUBLISH) begin
                        if (ps_remaining < 21'd2) raise_error();
                        else ps_phase = TLEN_HIGH;
                     end else if (ps_remaining == 21'd0) begin
                        close_packet();
                     end else begin
                        ps_phase = SKIP_BODY;
                     end
                  end
               end
            end
            default: begin
               bad_topic = 1'b0;
               ps_remaining = ps_remaining - 21'd1;
               case (ps_phase)
                  TLEN_HIGH: begin
                     ps_topic_len = {b, 8'h00};
                     ps_phase = TLEN_LOW;
                  end
                  TLEN_LOW: begin
                     ps_topic_len = {ps_topic_len[15:8], b};
                     ps_topic_left = ps_topic_len;
                     if (32'(ps_topic_len) > 32'(ps_remaining)) begin
                        bad_topic = 1'b1;
                     end else if (ps_qos != 2'd0 &&
                                  32'(ps_topic_len) + 32'd2 > 32'(ps_remaining)) begin
                        bad_topic = 1'b1;
                     end else if (ps_topic_left != 16'd0) begin
                        ps_phase = TOPIC_BYTES;
                     end else begin
                        ps_phase = (ps_qos != 2'd0) ? IDENT_HIGH : PAYLOAD_BYTES;
                     end
                  end
                  TOPIC_BYTES: begin
                     add_word(KIND_TOPIC, b);
                     ps_topic_left = ps_topic_left - 16'd1;
                     if (ps_topic_left == 16'd0)
                        ps_phase = (ps_qos != 2'd0) ? IDENT_HIGH : PAYLOAD_BYTES;
                  end
                  IDENT_HIGH: begin
                     ps_ident = {b, 8'h00};
                     ps_phase = IDENT_LOW;
                  end
                  IDENT_LOW: begin
                     ps_ident = {ps_ident[15:8], b};
                     add_word(KIND_REPLY, (ps_qos == QOS_ONE) ? HDR_PUBACK : HDR_PUBREC);
                     add_word(KIND_REPLY, REPLY_LEN);
                     add_word(KIND_REPLY, ps_ident[15:8]);
                     add_word(KIND_REPLY, ps_ident[7:0]);
                     ps_phase = PAYLOAD_BYTES;
                  end
                  PAYLOAD_BYTES: begin
                     add_word(KIND_PAYLOAD, b);
                  end
                  default: begin
                  end
               endcase
               if (bad_topic) raise_error();
               else if (ps_remaining == 21'd0) close_packet();
            end
         endcase
      end
      if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   function automatic void push_byte(logic [7:0] data, logic restart);
      rx_word_type w;
      w.data = data;
      w.conn_start = restart;
      rx_stream.push_back(w);
      gen_counted++;
   endfunction

   // Encode a remaining length, sometimes padded out with extra continuation bytes
   task automatic push_length(input int count);
      int nbytes;
      logic [7:0] digit;
      nbytes = (count < 128) ? 1 : (count < 16384) ? 2 : 3;
      if ($urandom_range(0, 3) == 0) nbytes = $urandom_range(nbytes, MAX_LEN_BYTES);
      for (int i = 0; i < nbytes; i++) begin
         digit = 8'((count >> (7 * i)) & 127);
         if (i < nbytes - 1) digit[7] = 1'b1;
         push_byte(digit, 1'b0);
      end
   endtask

   // Driver: present queued bytes, mirror each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            parse_byte(req_chan.in_byte, req_chan.conn_start);
            accepted_count <= accepted_count + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (rx_stream.size() == 0 || sender_hold ||
                $urandom_range(0, 99) < ((idle_phase == 2'd0) ? 25 :
                                         (idle_phase == 2'd1) ? 50 : 0)) begin
               req_chan.valid <= 1'b0;
            end else begin
               next_word = rx_stream.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.in_byte <= next_word.data;
               req_chan.conn_start <= next_word.conn_start;
            end
         end
      end
   end

   // Monitor: compare each result word with the oldest expected one
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: out_kind %0d out_byte %02h",
                      rsp_chan.out_kind, rsp_chan.out_byte);
               mismatch_count++;
            end else begin
               want_word = expected_words.pop_front();
               if (rsp_chan.out_kind !== want_word.kind) begin
                  $error("out_kind mismatch: expected %0d, got %0d",
                         want_word.kind, rsp_chan.out_kind);
                  mismatch_count++;
               end
               if (rsp_chan.out_byte !== want_word.data) begin
                  $error("out_byte mismatch: expected %02h, got %02h",
                         want_word.data, rsp_chan.out_byte);
                  mismatch_count++;
               end
               if (rsp_chan.out_qos !== want_word.qos) begin
                  $error("out_qos mismatch: expected %0d, got %0d",
                         want_word.qos, rsp_chan.out_qos);
                  mismatch_count++;
               end
               if (rsp_chan.out_last !== want_word.last) begin
                  $error("out_last mismatch: expected %0d, got %0d",
                         want_word.last, rsp_chan.out_last);
                  mismatch_count++;
               end
            end
         end
         // hold off once for a long stretch so the block backs up its input
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!long_hold_done && accepted_count >= (stream_total * 3) / 4) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= ((idle_phase == 2'd0) ? 50 :
                                                         (idle_phase == 2'd1) ? 25 : 0));
         end
      end
   end

   initial begin
      int pick;
      int qos;
      int tlen;
      int plen;
      int rem;
      int body;
      int directed_items;
      logic [3:0] ptype;
      rx_word_type noise;

      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.conn_start = 1'b0;
      rsp_chan.ready = 1'b0;

      // A CONNACK-type byte before CONNECT fails, then the halted parser drops a byte
      push_byte(8'h20, 1'b1);
      push_byte(8'h10, 1'b0);
      // connect, connect again, ping
      push_byte(8'h10, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h10, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hC0, 1'b0);
      push_byte(8'h00, 1'b0);
      // QoS 2 publish with DUP and RETAIN set: topic FF, id FF00, payload 00
      push_byte(8'h3D, 1'b0);
      push_byte(8'h06, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      // QoS bits 11 fail
      push_byte(8'h36, 1'b0);
      // four length bytes fail
      push_byte(8'h10, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h7F, 1'b0);
      // connect, disconnect, then a dropped byte
      push_byte(8'h10, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hE0, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h55, 1'b0);
      directed_items = gen_counted;

      // mostly well-formed packet sequences, with broken ones mixed in
      while (gen_counted < directed_items + RANDOM_ITEMS) begin
         if (!link_up) begin
            repeat ($urandom_range(0, 2)) begin
               noise.data = 8'($urandom);
               noise.conn_start = 1'b0;
               rx_stream.push_back(noise);
            end
         end
         if (!link_up || $urandom_range(0, 24) == 0) begin
            body = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            push_byte({PKT_CONNECT, 4'($urandom)}, 1'b1);
            push_length(body);
            repeat (body) push_byte(8'($urandom), 1'b0);
            link_up = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            qos = $urandom_range(0, 2);
            tlen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
            plen = $urandom_range(0, 6);
            rem = 2 + tlen + ((qos != 0) ? 2 : 0) + plen;
            push_byte({PKT_PUBLISH, 1'($urandom), 2'(qos), 1'($urandom)}, 1'b0);
            push_length(rem);
            push_byte(8'(tlen >> 8), 1'b0);
            push_byte(8'(tlen), 1'b0);
            repeat (tlen) push_byte(8'($urandom), 1'b0);
            if (qos != 0) begin
               push_byte(8'($urandom), 1'b0);
               push_byte(8'($urandom), 1'b0);
            end
            repeat (plen) push_byte(8'($urandom), 1'b0);
         end else if (pick < 58) begin
            push_byte({PKT_PINGREQ, 4'($urandom)}, 1'b0);
            push_length(0);
         end else if (pick < 68) begin
            // other types are skipped; a body now and then is long
            ptype = 4'($urandom);
            if (ptype == PKT_PUBLISH || ptype == PKT_PINGREQ || ptype == PKT_DISCONNECT)
               ptype = PKT_CONNECT;
            body = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 200) :
                                                  $urandom_range(0, 4);
            push_byte({ptype, 4'($urandom)}, 1'b0);
            push_length(body);
            repeat (body) push_byte(8'($urandom), 1'b0);
         end else if (pick < 72) begin
            body = $urandom_range(0, 2);
            push_byte({PKT_DISCONNECT, 4'($urandom)}, 1'b0);
            push_length(body);
            repeat (body) push_byte(8'($urandom), 1'b0);
            link_up = 1'b0;
         end else begin
            link_up = 1'b0;
            case ($urandom_range(0, 6))
               0: begin
                  // publish too short to hold a topic length
                  push_byte({PKT_PUBLISH, 1'($urandom), 2'($urandom_range(0, 2)),
                             1'($urandom)}, 1'b0);
                  push_length($urandom_range(0, 1));
               end
               1: begin
                  // topic longer than the rest of the packet
                  rem = $urandom_range(2, 6);
                  tlen = ($urandom_range(0, 1) == 0) ? rem - 1 : $urandom_range(rem - 1, 65535);
                  push_byte({PKT_PUBLISH, 1'($urandom), 2'($urandom_range(0, 2)),
                             1'($urandom)}, 1'b0);
                  push_length(rem);
                  push_byte(8'(tlen >> 8), 1'b0);
                  push_byte(8'(tlen), 1'b0);
               end
               2: begin
                  // topic leaves no room for the packet id
                  rem = $urandom_range(3, 7);
                  tlen = $urandom_range(rem - 3, rem - 2);
                  push_byte({PKT_PUBLISH, 1'($urandom), 2'($urandom_range(1, 2)),
                             1'($urandom)}, 1'b0);
                  push_length(rem);
                  push_byte(8'(tlen >> 8), 1'b0);
                  push_byte(8'(tlen), 1'b0);
               end
               3: begin
                  push_byte({PKT_PUBLISH, 1'($urandom), 2'd3, 1'($urandom)}, 1'b0);
               end
               4: begin
                  // length runs past the byte limit
                  ptype = 4'($urandom);
                  push_byte({ptype, (ptype == PKT_PUBLISH) ? 4'd0 : 4'($urandom)}, 1'b0);
                  repeat (MAX_LEN_BYTES) push_byte(8'($urandom) | 8'h80, 1'b0);
                  push_byte(8'($urandom), 1'b0);
               end
               5: begin
                  // cut a publish short; the next CONNECT restarts the link
                  push_byte({PKT_PUBLISH, 4'($urandom_range(0, 5))}, 1'b0);
                  push_length($urandom_range(3, 9));
                  repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
               end
               default: begin
                  // fresh connection that does not open with CONNECT
                  ptype = 4'($urandom);
                  if (ptype == PKT_CONNECT) ptype = PKT_PINGREQ;
                  push_byte({ptype, 4'($urandom)}, 1'b1);
               end
            endcase
         end
      end
      stream_total = rx_stream.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < stream_total / 3) @(posedge clock);
      idle_phase <= 2'd1;
      // pause the sender until every outstanding word has arrived
      while (accepted_count < stream_total / 2) @(posedge clock);
      sender_hold <= 1'b1;
      @(posedge clock);
      while (req_chan.valid || expected_words.size() != 0) @(posedge clock);
      sender_hold <= 1'b0;
      while (accepted_count < (stream_total * 2) / 3) @(posedge clock);
      idle_phase <= 2'd2;

      // drain
      while (accepted_count != stream_total) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("mqtt_server_packet_parser verification clean");
      end else begin
         $display("mqtt_server_packet_parser verification failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("mqtt_server_packet_parser verification failed");
      $finish;
   end

endmodule

@@ mqtt_server_packet_parser.f @@
+incdir+hdl
hdl/msp_pkg.sv
hdl/msp_if.sv
hdl/msp_front.sv
hdl/msp_fifo.sv
hdl/msp_back.sv
hdl/mqtt_server_packet_parser.sv
hdl/msp_checker.sv
tb/testbench.sv
